// File: rtl/acce_pkg.sv
// Shared types and codes of the Aho-Corasick censor engine.
package acce_pkg;

  localparam int SYM_W = 5;
  localparam int POS_W = 12;
  localparam int KEPT_W = 13;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_READ   = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TABLE_FULL = 3'd1,
    ST_PHASE      = 3'd2,
    ST_PAST_END   = 3'd3,
    ST_STACK_FULL = 3'd4
  } status_t;

  typedef struct packed {
    command_t           command;
    logic [SYM_W-1:0]   symbol;
    logic               pattern_end;
    logic [POS_W-1:0]   read_position;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [SYM_W-1:0]   letter_out;
    logic [KEPT_W-1:0]  kept_length;
    logic               censored;
  } result_t;

endpackage

// File: rtl/acce_if.sv
// Valid/ready channels for command beats and result beats.
interface acce_item_if;
  import acce_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acce_result_if;
  import acce_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/acce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/aho_corasick_censor_engine_unit.sv
// Censor engine: patterns go into a trie, a build pass makes the automaton, text letters
// are pushed on a stack and any pattern completed is popped off again. After reset the
// engine clears its goto, failure and pattern memories and takes no beat meanwhile.
// A text letter does a goto row read, a stack push with end-mark read, then a stack read
// to restore the match state after a removal; a beat refused for phase or a full stack,
// or with an ignored symbol, goes straight to the result.
// Build walks the trie breadth first with one goto row per node; the root and each queued
// node go through the row scan, which takes one letter a cycle. A finished result sits in
// an output register until taken.
module aho_corasick_censor_engine_unit #(
  parameter int NODE_COUNT = 1024,
  parameter int ALPHABET   = 26,
  parameter int TEXT_DEPTH = 4096
) (
  input logic          clk,
  input logic          rst,
  acce_item_if.sink    item,
  acce_result_if.source result
);
  import acce_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int USED_W = $clog2(NODE_COUNT + 1);
  localparam int LEN_W  = $clog2(NODE_COUNT + 1);
  localparam int C_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int ADDR_W = $clog2(TEXT_DEPTH);
  localparam int TOP_W  = $clog2(TEXT_DEPTH + 1);
  localparam int CMP_W  = ((LEN_W > TOP_W) ? LEN_W : TOP_W) + 1;
  localparam int ROW_W  = ALPHABET * NODE_W;
  localparam int PAT_W  = LEN_W + 1;
  localparam int STK_W  = SYM_W + NODE_W;

  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_INS    = 15'b000000000000100,
    S_TXT1   = 15'b000000000001000,
    S_TXT2   = 15'b000000000010000,
    S_TXT3   = 15'b000000000100000,
    S_RD     = 15'b000000001000000,
    S_B_ROOT = 15'b000000010000000,
    S_B_SCAN = 15'b000000100000000,
    S_B_WB   = 15'b000001000000000,
    S_B_POP  = 15'b000010000000000,
    S_B_U    = 15'b000100000000000,
    S_B_F    = 15'b001000000000000,
    S_B_FROW = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t state;

  // control state
  logic [NODE_W-1:0] clr_addr;
  logic [USED_W-1:0] nodes_used;
  logic [NODE_W-1:0] cursor;
  logic [LEN_W-1:0]  depth;
  logic              built;
  logic [TOP_W-1:0]  top;
  logic [NODE_W-1:0] match;
  logic [USED_W-1:0] head;
  logic [USED_W-1:0] tail;
  logic [C_W-1:0]    col;
  logic              res_valid;

  // payload registers
  item_t             item_q;
  row_t              urow;
  row_t              frow;
  logic [NODE_W-1:0] u_node;
  status_t           status;
  logic [SYM_W-1:0]  letter;
  logic              censored;
  result_t           res_data;

  // memory ports
  logic              gt_we, fl_we, pat_we, q_we, stk_we;
  logic [NODE_W-1:0] gt_waddr, gt_raddr, fl_waddr, fl_raddr, pat_waddr, pat_raddr;
  logic [NODE_W-1:0] q_waddr, q_raddr;
  row_t              gt_wdata, gt_rdata;
  logic [NODE_W-1:0] fl_wdata, fl_rdata, q_wdata, q_rdata;
  logic [PAT_W-1:0]  pat_wdata, pat_rdata;
  logic [ADDR_W-1:0] stk_waddr, stk_raddr;
  logic [STK_W-1:0]  stk_wdata, stk_rdata;

  logic              item_fire;
  logic [NODE_W-1:0] ins_edge, ins_next, txt_node, cur_child;
  logic              ins_new, ins_ok;
  logic [CMP_W-1:0]  top_ext, len_ext;
  logic [TOP_W-1:0]  new_top;

  assign item_fire  = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign result.valid = res_valid;
  assign result.data  = res_data;

  assign ins_edge  = gt_rdata[C_W'(item_q.symbol)];
  assign ins_new   = (ins_edge == '0);
  assign ins_ok    = !ins_new || (nodes_used < USED_W'(NODE_COUNT));
  assign ins_next  = ins_new ? NODE_W'(nodes_used) : ins_edge;
  assign txt_node  = gt_rdata[C_W'(item_q.symbol)];
  assign cur_child = urow[col];
  assign top_ext   = CMP_W'(top);
  assign len_ext   = CMP_W'(pat_rdata[LEN_W-1:0]);
  assign new_top   = (len_ext >= top_ext) ? '0 : TOP_W'(top_ext - len_ext);

  always_comb begin
    row_t ins_row;
    ins_row = gt_rdata;
    ins_row[C_W'(item_q.symbol)] = ins_next;

    gt_we = 1'b0;  gt_waddr = cursor;  gt_wdata = ins_row;  gt_raddr = '0;
    fl_we = 1'b0;  fl_waddr = cur_child;  fl_wdata = frow[col];  fl_raddr = q_rdata;
    pat_we = 1'b0; pat_waddr = ins_next;  pat_raddr = txt_node;
    pat_wdata = {1'b1, LEN_W'(depth + 1'b1)};
    q_we = 1'b0;   q_waddr = tail[NODE_W-1:0];  q_wdata = cur_child;
    q_raddr = head[NODE_W-1:0];
    stk_we = 1'b0; stk_waddr = top[ADDR_W-1:0];  stk_wdata = {item_q.symbol, txt_node};
    stk_raddr = ADDR_W'(item.data.read_position);

    unique case (state)
      S_CLEAR: begin
        gt_we = 1'b1;  gt_waddr = clr_addr;  gt_wdata = '0;
        fl_we = 1'b1;  fl_waddr = clr_addr;  fl_wdata = '0;
        pat_we = 1'b1; pat_waddr = clr_addr; pat_wdata = '0;
      end
      S_IDLE: begin
        case (item.data.command)
          CMD_INSERT: gt_raddr = cursor;
          CMD_TEXT:   gt_raddr = match;
          default:    gt_raddr = '0;
        endcase
      end
      S_INS: begin
        gt_we  = ins_new && ins_ok;
        pat_we = ins_ok && item_q.pattern_end;
      end
      S_TXT1: stk_we = 1'b1;
      S_TXT2: stk_raddr = ADDR_W'(new_top - 1'b1);
      S_B_SCAN: begin
        fl_we = (cur_child != '0);
        q_we  = (cur_child != '0) && (tail < USED_W'(NODE_COUNT));
      end
      S_B_WB: begin
        gt_we = 1'b1;  gt_waddr = u_node;  gt_wdata = urow;
      end
      S_B_U: gt_raddr = q_rdata;
      S_B_F: gt_raddr = fl_rdata;
      S_TXT3, S_RD, S_B_ROOT, S_B_POP, S_B_FROW, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      nodes_used <= USED_W'(1);
      cursor     <= '0;
      depth      <= '0;
      built      <= 1'b0;
      top        <= '0;
      match      <= '0;
      head       <= '0;
      tail       <= '0;
      col        <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == NODE_W'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_fire) begin
            item_q   <= item.data;
            letter   <= '0;
            censored <= 1'b0;
            unique case (item.data.command)
              CMD_INSERT: begin
                if (built) begin
                  status <= ST_PHASE;
                  state  <= S_DONE;
                end else begin
                  status <= ST_OK;
                  state  <= (item.data.symbol < ALPHABET) ? S_INS : S_DONE;
                end
              end
              CMD_BUILD: begin
                if (built) begin
                  status <= ST_PHASE;
                  state  <= S_DONE;
                end else begin
                  status <= ST_OK;
                  head   <= '0;
                  tail   <= '0;
                  state  <= S_B_ROOT;
                end
              end
              CMD_TEXT: begin
                if (!built) begin
                  status <= ST_PHASE;
                  state  <= S_DONE;
                end else if (item.data.symbol >= ALPHABET) begin
                  status <= ST_OK;
                  state  <= S_DONE;
                end else if (top >= TOP_W'(TEXT_DEPTH)) begin
                  status <= ST_STACK_FULL;
                  state  <= S_DONE;
                end else begin
                  status <= ST_OK;
                  state  <= S_TXT1;
                end
              end
              CMD_READ: begin
                if (item.data.read_position >= top) begin
                  status <= ST_PAST_END;
                  state  <= S_DONE;
                end else begin
                  status <= ST_OK;
                  state  <= S_RD;
                end
              end
              default: begin
                status <= ST_OK;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          state <= S_DONE;
          if (!ins_ok) begin
            status <= ST_TABLE_FULL;
          end else begin
            if (ins_new) nodes_used <= nodes_used + 1'b1;
            if (item_q.pattern_end) begin
              cursor <= '0;
              depth  <= '0;
            end else begin
              cursor <= ins_next;
              depth  <= depth + 1'b1;
            end
          end
        end
        S_TXT1: begin
          match <= txt_node;
          top   <= top + 1'b1;
          state <= S_TXT2;
        end
        S_TXT2: begin
          if (pat_rdata[LEN_W]) begin
            censored <= 1'b1;
            top      <= new_top;
            if (new_top == '0) begin
              match <= '0;
              state <= S_DONE;
            end else begin
              state <= S_TXT3;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_TXT3: begin
          match <= stk_rdata[NODE_W-1:0];
          state <= S_DONE;
        end
        S_RD: begin
          letter <= stk_rdata[STK_W-1:NODE_W];
          state  <= S_DONE;
        end
        // the root row goes through the same scan with an all-zero failure row
        S_B_ROOT: begin
          urow   <= gt_rdata;
          frow   <= '0;
          u_node <= '0;
          col    <= '0;
          state  <= S_B_SCAN;
        end
        S_B_SCAN: begin
          if (cur_child != '0) begin
            if (tail < USED_W'(NODE_COUNT)) tail <= tail + 1'b1;
          end else begin
            urow[col] <= frow[col];
          end
          col <= col + 1'b1;
          if (col == C_W'(ALPHABET - 1)) state <= S_B_WB;
        end
        S_B_WB: state <= S_B_POP;
        S_B_POP: begin
          if (head < tail) begin
            head  <= head + 1'b1;
            state <= S_B_U;
          end else begin
            cursor <= '0;
            depth  <= '0;
            built  <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_B_U: begin
          u_node <= q_rdata;
          state  <= S_B_F;
        end
        S_B_F: begin
          urow  <= gt_rdata;
          state <= S_B_FROW;
        end
        S_B_FROW: begin
          frow  <= gt_rdata;
          col   <= '0;
          state <= S_B_SCAN;
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || result.ready)) begin
      res_data.status      <= status;
      res_data.letter_out  <= letter;
      res_data.kept_length <= KEPT_W'(top);
      res_data.censored    <= censored;
    end
  end

  acce_ram #(.WIDTH(ROW_W), .DEPTH(NODE_COUNT)) u_goto (
    .clk(clk), .we(gt_we), .waddr(gt_waddr), .wdata(gt_wdata),
    .raddr(gt_raddr), .rdata(gt_rdata)
  );

  acce_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_fail (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  acce_ram #(.WIDTH(PAT_W), .DEPTH(NODE_COUNT)) u_pat (
    .clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
    .raddr(pat_raddr), .rdata(pat_rdata)
  );

  acce_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  acce_ram #(.WIDTH(STK_W), .DEPTH(TEXT_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

endmodule
